[hdl/hvd_pkg.sv]
package hvd_pkg;

	localparam int VW = 34;

	localparam logic signed [VW-1:0] FULL_TURN    = 34'sd6039797760;
	localparam logic [32:0]          HALF_TURN    = 33'd3019898880;
	localparam logic [32:0]          QUARTER_TURN = 33'd1509949440;
	localparam logic [26:0]          DEG_TO_RAD_Q32 = 27'd74961321;
	localparam logic [31:0]          GAIN_Q30     = 32'd652032874;
	localparam logic [32:0]          DIST_MAX     = 33'd6746518912;
	localparam logic [22:0]          RADIUS_RST   = 23'd6371000;

	localparam logic [31:0] ATAN_LOW [10] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD
	};

	function automatic logic [31:0] atan_entry(input int i, input int f);
		logic [31:0] q;
		int ii;
		ii = i & 31;
		if (ii < 10) begin
			q = ATAN_LOW[ii];
		end else if (ii <= 30) begin
			q = 32'd1 << (30 - ii);
		end else begin
			q = 32'd0;
		end
		return (q + (32'd1 << (29 - f))) >> (30 - f);
	endfunction

endpackage

[hdl/hvd_rot_cell.sv]
module hvd_rot_cell import hvd_pkg::*; #(
	parameter int W   = 26,
	parameter int F   = 23,
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] x_in,
	input  logic signed [W-1:0] y_in,
	input  logic signed [W-1:0] z_in,
	input  logic                tag_in,
	output logic signed [W-1:0] x_q,
	output logic signed [W-1:0] y_q,
	output logic signed [W-1:0] z_q,
	output logic                tag_q
);

	localparam logic signed [W-1:0] T = W'(atan_entry(IDX, F));

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q <= tag_in;
			if (z_in >= 0) begin
				x_q <= x_in - (y_in >>> IDX);
				y_q <= y_in + (x_in >>> IDX);
				z_q <= z_in - T;
			end else begin
				x_q <= x_in + (y_in >>> IDX);
				y_q <= y_in - (x_in >>> IDX);
				z_q <= z_in + T;
			end
		end
	end

endmodule

[hdl/hvd_vec_cell.sv]
module hvd_vec_cell import hvd_pkg::*; #(
	parameter int W   = 26,
	parameter int F   = 23,
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] x_in,
	input  logic signed [W-1:0] y_in,
	input  logic signed [W-1:0] z_in,
	output logic signed [W-1:0] x_q,
	output logic signed [W-1:0] y_q,
	output logic signed [W-1:0] z_q
);

	localparam logic signed [W-1:0] T = W'(atan_entry(IDX, F));

	always_ff @(posedge clk) begin
		if (en) begin
			if (y_in >= 0) begin
				x_q <= x_in + (y_in >>> IDX);
				y_q <= y_in - (x_in >>> IDX);
				z_q <= z_in + T;
			end else begin
				x_q <= x_in - (y_in >>> IDX);
				y_q <= y_in + (x_in >>> IDX);
				z_q <= z_in - T;
			end
		end
	end

endmodule

[hdl/hvd_sqrt_cell.sv]
module hvd_sqrt_cell import hvd_pkg::*; #(
	parameter int D = 24
) (
	input  logic           clk,
	input  logic           en,
	input  logic [D+1:0]   rem_in,
	input  logic [D-1:0]   root_in,
	input  logic [2*D-1:0] n_in,
	output logic [D+1:0]   rem_q,
	output logic [D-1:0]   root_q,
	output logic [2*D-1:0] n_q
);

	logic [D+3:0] rem_sh;
	logic [D+3:0] trial;

	always_comb begin
		rem_sh = {rem_in, n_in[2*D-1 -: 2]};
		trial  = {2'b00, root_in, 2'b01};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_q <= n_in << 2;
			if (rem_sh >= trial) begin
				rem_q  <= (D+2)'(rem_sh - trial);
				root_q <= {root_in[D-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[D+1:0];
				root_q <= {root_in[D-2:0], 1'b0};
			end
		end
	end

endmodule

[hdl/haversine_distance.sv]
// Haversine great-circle distance.
// Input channel (in_valid/in_stall) carries two points as latitude and
// longitude in signed degrees, LSB 2^-23 degree. A request is taken at a
// rising edge with in_valid high and in_stall low.
// Output channel (out_valid/out_stall) carries distance in meters with 8
// fraction bits, saturated. The result is taken with out_valid high and
// out_stall low.
// Config channel (cfg_valid/cfg_ready) writes the sphere radius; cfg_ready
// is always high. Write only while the pipeline is empty.
// The pipeline runs through the four rotation CORDIC rows, the square root
// digit rows and the vectoring CORDIC row. One request is taken per cycle
// while the pipeline is not stalled.
// A stalled result holds the whole pipeline in place and raises in_stall
// until the result is taken.
// Reset empties the pipeline and sets the radius to 6371000 m.
module haversine_distance import hvd_pkg::*; #(
	parameter int CORDIC_STAGES   = 24,
	parameter int ANGLE_FRAC_BITS = 23
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [30:0] first_latitude,
	input  logic signed [31:0] first_longitude,
	input  logic signed [30:0] second_latitude,
	input  logic signed [31:0] second_longitude,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [32:0]        distance,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [22:0]        cfg_sphere_radius_m
);

	localparam int C  = CORDIC_STAGES;
	localparam int F  = ANGLE_FRAC_BITS;
	localparam int W  = F + 3;
	localparam int D  = F + 1;
	localparam int PW = 23 + W + 1;
	localparam int L  = 2 * C + F + 16;
	localparam logic [63:0] GAIN_R64 =
		(64'(GAIN_Q30) + (64'd1 << (29 - F))) >> (30 - F);
	localparam logic signed [W-1:0] X0 = W'(GAIN_R64);
	localparam logic [2*F:0] ONE = (2*F+1)'(1) << (2 * F);

	logic         en;
	logic [L-1:0] vld_q;
	logic [22:0]  radius_q;

	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[L-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			radius_q <= RADIUS_RST;
		end else begin
			if (en) begin
				vld_q <= {vld_q[L-2:0], in_valid};
			end
			if (cfg_valid) begin
				radius_q <= cfg_sphere_radius_m;
			end
		end
	end

	logic signed [VW-1:0] v_s1 [4];
	logic [32:0]          r_s2 [4];
	logic [32:0]          r_s3 [4];
	logic [30:0]          r_s4 [4];
	logic                 neg_s4 [4];
	logic [57:0]          p_s5 [4];
	logic                 neg_s5 [4];
	logic signed [W-1:0]  z_s6 [4];
	logic                 neg_s6 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1[0] <= VW'(second_latitude) - VW'(first_latitude);
			v_s1[1] <= VW'(second_longitude) - VW'(first_longitude);
			v_s1[2] <= VW'(first_latitude) <<< 1;
			v_s1[3] <= VW'(second_latitude) <<< 1;
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_front
		logic [32:0] fold3;
		logic [32:0] fold4;
		always_comb begin
			fold3 = (r_s2[g] >= HALF_TURN) ? 33'(FULL_TURN) - r_s2[g] : r_s2[g];
			fold4 = (r_s3[g] > QUARTER_TURN) ? HALF_TURN - r_s3[g] : r_s3[g];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				r_s2[g]   <= (v_s1[g] < 0) ? 33'(v_s1[g] + FULL_TURN) : 33'(v_s1[g]);
				r_s3[g]   <= fold3;
				r_s4[g]   <= fold4[30:0];
				neg_s4[g] <= r_s3[g] > QUARTER_TURN;
				p_s5[g]   <= 58'(r_s4[g]) * 58'(DEG_TO_RAD_Q32);
				neg_s5[g] <= neg_s4[g];
				z_s6[g]   <= W'((p_s5[g] + (58'd1 << (55 - F))) >> (56 - F));
				neg_s6[g] <= neg_s5[g];
			end
		end
	end

	logic signed [W-1:0] rx [4][C+1];
	logic signed [W-1:0] ry [4][C+1];
	logic signed [W-1:0] rz [4][C+1];
	logic                rt [4][C+1];

	for (genvar g = 0; g < 4; g++) begin : g_rot
		assign rx[g][0] = X0;
		assign ry[g][0] = '0;
		assign rz[g][0] = z_s6[g];
		assign rt[g][0] = neg_s6[g];
		for (genvar k = 0; k < C; k++) begin : g_cell
			hvd_rot_cell #(.W(W), .F(F), .IDX(k)) u_cell (
				.clk    (clk),
				.en     (en),
				.x_in   (rx[g][k]),
				.y_in   (ry[g][k]),
				.z_in   (rz[g][k]),
				.tag_in (rt[g][k]),
				.x_q    (rx[g][k+1]),
				.y_q    (ry[g][k+1]),
				.z_q    (rz[g][k+1]),
				.tag_q  (rt[g][k+1])
			);
		end
	end

	logic signed [W-1:0]   slat, slon, cos1, cos2;
	logic signed [W-1:0]   mag1, mag2;

	always_comb begin
		slat = (ry[0][C] < 0) ? '0 : ry[0][C];
		slon = (ry[1][C] < 0) ? '0 : ry[1][C];
		mag1 = (rx[2][C] < 0) ? '0 : rx[2][C];
		mag2 = (rx[3][C] < 0) ? '0 : rx[3][C];
		cos1 = rt[2][C] ? -mag1 : mag1;
		cos2 = rt[3][C] ? -mag2 : mag2;
	end

	logic signed [2*W-1:0] a_m1, cp_m1;
	logic [W-1:0]          sl_m1, sl_m2, sl_m3, sl_m4;
	logic [2*W-1:0]        a_m2, a_m3, a_m4, a_m5;
	logic                  neg_m2, neg_m3, neg_m4, neg_m5;
	logic [W-1:0]          t_m2, t2_m4;
	logic [2*W-1:0]        u_m3, term_m5;
	logic [2*F:0]          ac_m6;
	logic [2*D-1:0]        na_m7, nb_m7;
	logic [2*W-1:0]        cp_abs;
	logic signed [2*W+1:0] asum;

	always_comb begin
		cp_abs = (cp_m1 < 0) ? (2*W)'(-cp_m1) : (2*W)'(cp_m1);
		asum   = neg_m5 ? $signed({2'b00, a_m5}) - $signed({2'b00, term_m5})
		                : $signed({2'b00, a_m5}) + $signed({2'b00, term_m5});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_m1    <= slat * slat;
			cp_m1   <= cos1 * cos2;
			sl_m1   <= slon;
			t_m2    <= W'((cp_abs + ((2*W)'(1) << (F - 1))) >> F);
			neg_m2  <= cp_m1 < 0;
			a_m2    <= a_m1;
			sl_m2   <= sl_m1;
			u_m3    <= (2*W)'(t_m2) * (2*W)'(sl_m2);
			a_m3    <= a_m2;
			neg_m3  <= neg_m2;
			sl_m3   <= sl_m2;
			t2_m4   <= W'((u_m3 + ((2*W)'(1) << (F - 1))) >> F);
			a_m4    <= a_m3;
			neg_m4  <= neg_m3;
			sl_m4   <= sl_m3;
			term_m5 <= (2*W)'(t2_m4) * (2*W)'(sl_m4);
			a_m5    <= a_m4;
			neg_m5  <= neg_m4;
			if (asum < 0) begin
				ac_m6 <= '0;
			end else if (asum > $signed((2*W+2)'(ONE))) begin
				ac_m6 <= ONE;
			end else begin
				ac_m6 <= (2*F+1)'(asum);
			end
			na_m7 <= (2*D)'(ac_m6);
			nb_m7 <= (2*D)'(ONE - ac_m6);
		end
	end

	logic [D+1:0]   sr_rem  [2][D+1];
	logic [D-1:0]   sr_root [2][D+1];
	logic [2*D-1:0] sr_n    [2][D+1];

	assign sr_n[0][0] = na_m7;
	assign sr_n[1][0] = nb_m7;

	for (genvar g = 0; g < 2; g++) begin : g_sqrt
		assign sr_rem[g][0]  = '0;
		assign sr_root[g][0] = '0;
		for (genvar k = 0; k < D; k++) begin : g_cell
			hvd_sqrt_cell #(.D(D)) u_cell (
				.clk     (clk),
				.en      (en),
				.rem_in  (sr_rem[g][k]),
				.root_in (sr_root[g][k]),
				.n_in    (sr_n[g][k]),
				.rem_q   (sr_rem[g][k+1]),
				.root_q  (sr_root[g][k+1]),
				.n_q     (sr_n[g][k+1])
			);
		end
	end

	logic signed [W-1:0] vx [C+1];
	logic signed [W-1:0] vy [C+1];
	logic signed [W-1:0] vz [C+1];

	assign vy[0] = W'(sr_root[0][D]);
	assign vx[0] = W'(sr_root[1][D]);
	assign vz[0] = '0;

	for (genvar k = 0; k < C; k++) begin : g_vec
		hvd_vec_cell #(.W(W), .F(F), .IDX(k)) u_cell (
			.clk  (clk),
			.en   (en),
			.x_in (vx[k]),
			.y_in (vy[k]),
			.z_in (vz[k]),
			.x_q  (vx[k+1]),
			.y_q  (vy[k+1]),
			.z_q  (vz[k+1])
		);
	end

	logic [W:0]    ang2;
	logic [PW-1:0] prod_d1;
	logic [PW-1:0] dist_r;

	always_comb begin
		ang2   = (vz[C] < 0) ? '0 : {vz[C][W-2:0], 1'b0, 1'b0} >> 1;
		dist_r = (prod_d1 + (PW'(1) << (F - 9))) >> (F - 8);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_d1  <= PW'(radius_q) * PW'(ang2);
			distance <= (dist_r > PW'(DIST_MAX)) ? DIST_MAX : 33'(dist_r);
		end
	end

endmodule
